@@ src/tchg_pkg.sv @@
// Shared types and constants for the tap-count/hold gesture detector.
// No dependencies; used by tchg_ctrl, tchg_dp and the top level.
package tchg_pkg;

  typedef struct packed {
    logic        press_edge;
    logic        button_down;
    logic [11:0] elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0] action;
    logic [8:0] cue_level;
  } out_item_t;

  typedef struct packed {
    logic load_poll;
    logic div_init;
    logic div_step;
    logic out_load;
  } ctrl_cmd_t;

  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam int CNT_BITS = 4;
  localparam int CFG_TIME_BITS = 16;
  localparam int DT_BITS = 12;
  localparam int DIV_STEPS = 8;
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_BITS-1:0] CFG_REBOOT_COUNT = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FORM_COUNT   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CAL_COUNT    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COUNT_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TAP_MAX      = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GAP_TIME     = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD_TIME    = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CUE_TIME     = 3'd7;

  localparam logic [1:0] ACT_NONE      = 2'd0;
  localparam logic [1:0] ACT_REBOOT    = 2'd1;
  localparam logic [1:0] ACT_FORM      = 2'd2;
  localparam logic [1:0] ACT_CALIBRATE = 2'd3;

  localparam logic [8:0] CUE_FULL = 9'd256;

  function automatic logic [1:0] pick_action(
    input logic [CNT_BITS-1:0] count,
    input logic [CNT_BITS-1:0] reboot_cnt,
    input logic [CNT_BITS-1:0] form_cnt,
    input logic [CNT_BITS-1:0] cal_cnt
  );
    logic [1:0] act;
    act = ACT_NONE;
    if (count != '0) begin
      if (count == reboot_cnt) act = ACT_REBOOT;
      else if (count == form_cnt) act = ACT_FORM;
      else if (count == cal_cnt) act = ACT_CALIBRATE;
    end
    return act;
  endfunction

endpackage

@@ src/tchg_ctrl.sv @@
// Sequencer for the gesture detector: accept, cue setup, serial divide, output.
// Depends on tchg_pkg; drives the command struct into tchg_dp.
module tchg_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output tchg_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_PREP   = 4'b0010,
    ST_DIVIDE = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [tchg_pkg::DIV_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_poll = 1'b1;
          state_nxt     = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == tchg_pkg::DIV_CNT_BITS'(tchg_pkg::DIV_STEPS - 1)) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ src/tchg_dp.sv @@
// Datapath: configuration registers, gesture state, cue divider, output register.
// Depends on tchg_pkg; steered by the command struct from tchg_ctrl.
module tchg_dp #(
  parameter int TIME_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [tchg_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [tchg_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  tchg_pkg::in_item_t                   in_data,
  input  tchg_pkg::ctrl_cmd_t                  cmd,
  output tchg_pkg::out_item_t                  out_data
);

  localparam int TB = tchg_pkg::CFG_TIME_BITS;
  localparam int NB = tchg_pkg::CNT_BITS;
  localparam int CW = (TIME_BITS > TB) ? TIME_BITS : TB;
  localparam int AW = ((TIME_BITS > tchg_pkg::DT_BITS) ? TIME_BITS : tchg_pkg::DT_BITS) + 1;
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  logic [NB-1:0] reboot_cnt_r, form_cnt_r, cal_cnt_r, limit_r;
  logic [TB-1:0] tap_max_r, gap_r, hold_r, cue_r;

  logic [NB-1:0]        tap_r, tap_nxt;
  logic [NB-1:0]        armed_r, armed_nxt;
  logic [TIME_BITS-1:0] press_r, press_nxt;
  logic [TIME_BITS-1:0] idle_r, idle_nxt;
  logic [1:0]           act_r, act_nxt;

  logic [TB-1:0]  rem_r;
  logic [7:0]     quot_r;
  logic           cue_zero_r, cue_full_r;
  logic [TB:0]    rem_dbl;
  logic           rem_ge;
  logic [TB:0]    rem_sub;
  logic [CW-1:0]  press_ext;
  tchg_pkg::out_item_t out_r;

  function automatic logic [TIME_BITS-1:0] sat_add(
    input logic [TIME_BITS-1:0] a,
    input logic [tchg_pkg::DT_BITS-1:0] b
  );
    logic [AW-1:0] s;
    s = AW'(a) + AW'(b);
    return (s > AW'(TIME_MAX)) ? TIME_MAX : s[TIME_BITS-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reboot_cnt_r <= NB'(5);
      form_cnt_r   <= NB'(3);
      cal_cnt_r    <= NB'(2);
      limit_r      <= NB'(8);
      tap_max_r    <= TB'(300);
      gap_r        <= TB'(500);
      hold_r       <= TB'(2000);
      cue_r        <= TB'(500);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        tchg_pkg::CFG_REBOOT_COUNT: reboot_cnt_r <= cfg_data[NB-1:0];
        tchg_pkg::CFG_FORM_COUNT:   form_cnt_r   <= cfg_data[NB-1:0];
        tchg_pkg::CFG_CAL_COUNT:    cal_cnt_r    <= cfg_data[NB-1:0];
        tchg_pkg::CFG_COUNT_LIMIT:  limit_r      <= cfg_data[NB-1:0];
        tchg_pkg::CFG_TAP_MAX:      tap_max_r    <= cfg_data[TB-1:0];
        tchg_pkg::CFG_GAP_TIME:     gap_r        <= cfg_data[TB-1:0];
        tchg_pkg::CFG_HOLD_TIME:    hold_r       <= cfg_data[TB-1:0];
        tchg_pkg::CFG_CUE_TIME:     cue_r        <= cfg_data[TB-1:0];
        default: ;
      endcase
    end
  end

  // one poll of the gesture state
  always_comb begin
    tap_nxt   = tap_r;
    armed_nxt = armed_r;
    press_nxt = press_r;
    idle_nxt  = idle_r;
    act_nxt   = tchg_pkg::ACT_NONE;
    if (in_data.press_edge) begin
      if (tap_nxt != '0 && CW'(idle_r) > CW'(gap_r)) tap_nxt = '0;
      press_nxt = '0;
      armed_nxt = '0;
    end
    if (in_data.button_down) begin
      press_nxt = sat_add(press_nxt, in_data.elapsed_ms);
      if (armed_nxt == '0 && CW'(press_nxt) > CW'(tap_max_r)) armed_nxt = tap_nxt;
      if (armed_nxt != '0 && CW'(press_nxt) >= CW'(hold_r)) begin
        act_nxt   = tchg_pkg::pick_action(armed_nxt, reboot_cnt_r, form_cnt_r, cal_cnt_r);
        tap_nxt   = '0;
        armed_nxt = '0;
        press_nxt = '0;
        idle_nxt  = '0;
      end
    end else if (press_nxt != '0) begin
      if (CW'(press_nxt) <= CW'(tap_max_r)) begin
        if (tap_nxt < limit_r) tap_nxt = tap_nxt + 1'b1;
      end else begin
        tap_nxt = '0;
      end
      press_nxt = '0;
      armed_nxt = '0;
      idle_nxt  = '0;
    end else begin
      idle_nxt = sat_add(idle_r, in_data.elapsed_ms);
      if (tap_nxt != '0 && CW'(idle_nxt) > CW'(gap_r)) tap_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r   <= '0;
      armed_r <= '0;
      press_r <= '0;
      idle_r  <= '0;
    end else if (cmd.load_poll) begin
      tap_r   <= tap_nxt;
      armed_r <= armed_nxt;
      press_r <= press_nxt;
      idle_r  <= idle_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_poll) act_r <= act_nxt;
  end

  // restoring divider: press * 256 / hold, result used only when press < hold
  assign press_ext = CW'(press_r);
  assign rem_dbl   = {rem_r, 1'b0};
  assign rem_ge    = rem_dbl >= {1'b0, hold_r};
  assign rem_sub   = rem_dbl - {1'b0, hold_r};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      cue_zero_r <= (tchg_pkg::pick_action(armed_r, reboot_cnt_r, form_cnt_r, cal_cnt_r)
                     == tchg_pkg::ACT_NONE) || (press_ext < CW'(cue_r));
      cue_full_r <= press_ext >= CW'(hold_r);
      rem_r      <= press_ext[TB-1:0];
      quot_r     <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= rem_ge ? rem_sub[TB-1:0] : rem_dbl[TB-1:0];
      quot_r <= {quot_r[6:0], rem_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.action <= act_r;
      if (cue_zero_r) out_r.cue_level <= '0;
      else if (cue_full_r) out_r.cue_level <= tchg_pkg::CUE_FULL;
      else out_r.cue_level <= {1'b0, quot_r};
    end
  end

  assign out_data = out_r;

endmodule

@@ src/tap_count_hold_gesture_detector.sv @@
// Tap-count/hold gesture detector, top level.
// Depends on tchg_pkg, tchg_ctrl and tchg_dp.
//
// One result per poll. A poll is taken when in_valid and in_ready are both high;
// the gesture state is updated at that edge, then the cue fraction is worked out
// by an 8-step restoring divider; the result is loaded into the output register
// in ST_DONE once that register is free, and the next poll can be taken after that.
// The output register lets a new poll be taken while the previous result waits.
// Configuration writes via cfg_wr_en/cfg_index/cfg_data take effect at once; the
// user must keep them to idle time, as the block itself does not enforce this.
module tap_count_hold_gesture_detector #(
  parameter int TIME_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [tchg_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [tchg_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  tchg_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output tchg_pkg::out_item_t                 out_data
);

  tchg_pkg::ctrl_cmd_t cmd;

  tchg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  tchg_dp #(
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_data  (out_data)
  );

endmodule
